[hw/rtl/image_flip_transpose_unit_defines.svh]
// Assertion macros used by the checker file of the flip/transpose unit.
`ifndef IMAGE_FLIP_TRANSPOSE_UNIT_DEFINES_SVH
`define IMAGE_FLIP_TRANSPOSE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ift_pkg.sv]
// Shared types and constants for the image flip/transpose unit.
package ift_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int SIZE_BITS  = 9;
  localparam int POS_BITS   = 2 * SIZE_BITS;
  localparam int WORD_BITS  = 16;
  localparam int INDEX_BITS = 3;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(256);

  typedef enum logic [INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_MIRROR_H     = 3'd2,
    REG_MIRROR_V     = 3'd3,
    REG_SWAP_AXES    = 3'd4
  } cfg_reg_t;

  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_REGION = 1'b1;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REGION = 1'b1;

endpackage

[hw/rtl/image_flip_transpose_unit.sv]
// Image flip/transpose unit: ping-pong frame buffer with mirror and transpose.
//
// One item is taken in every clock cycle: busy is always low. Each item gives
// exactly one result, shown for a single cycle with done high on the cycle
// after the item is taken; the receiver cannot stall and must take it then.
// A pixel item is written to one bank of the frame buffer while one pixel of
// the previous frame is read from the other bank; the memory does one write
// and one read per pixel item, setting the rate. Results stay invalid until
// one full frame has been written. The buffer is not cleared after reset. The
// user writes configuration only while no item is in flight; not enforced.
module image_flip_transpose_unit
  import ift_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  wr_en,
  input  logic [INDEX_BITS-1:0] wr_index,
  input  logic [SIZE_BITS-1:0]  wr_data,
  input  logic                  op,
  input  logic [WORD_BITS-1:0]  pixel_in,
  input  logic [WORD_BITS-1:0]  region_x_start,
  input  logic [WORD_BITS-1:0]  region_x_end,
  input  logic [WORD_BITS-1:0]  region_y_start,
  input  logic [WORD_BITS-1:0]  region_y_end,
  output logic                  done,
  output logic                  result_kind,
  output logic [WORD_BITS-1:0]  pixel_out,
  output logic                  pixel_valid,
  output logic                  frame_last,
  output logic [WORD_BITS-1:0]  out_x_start,
  output logic [WORD_BITS-1:0]  out_x_end,
  output logic [WORD_BITS-1:0]  out_y_start,
  output logic [WORD_BITS-1:0]  out_y_end,
  output logic [SIZE_BITS-1:0]  out_width,
  output logic [SIZE_BITS-1:0]  out_height
);

  localparam int BANK_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW        = $clog2(BANK_SIZE);
  // bank select sits above the in-bank address bits
  localparam int MEM_DEPTH = 2 ** (AW + 1);

  // configuration
  logic [SIZE_BITS-1:0] frame_width;
  logic [SIZE_BITS-1:0] frame_height;
  logic                 mirror_horizontal;
  logic                 mirror_vertical;
  logic                 swap_axes;

  // frame counters
  logic [POS_BITS-1:0]  write_position;
  logic [SIZE_BITS-1:0] read_row;
  logic [SIZE_BITS-1:0] read_column;
  logic                 active_bank;
  logic                 previous_ready;

  // result register
  logic                 res_valid;
  logic                 res_last;
  logic [PIXEL_BITS-1:0] rd_data;

  logic [PIXEL_BITS-1:0] mem [MEM_DEPTH];

  logic                 accept;
  logic                 pix_accept;
  logic [SIZE_BITS-1:0] ew, eh, ow, oh;
  logic [POS_BITS-1:0]  total;
  logic [POS_BITS-1:0]  wp_cur, wp_inc;
  logic [SIZE_BITS-1:0] rc_cur, rr_cur;
  logic [SIZE_BITS:0]   rc_inc, rr_inc;
  logic [SIZE_BITS-1:0] mrow, mcol, sx, sy;
  logic [POS_BITS-1:0]  src;
  logic                 frame_wrap, col_wrap, last_c;
  logic [AW:0]          wr_addr, rd_addr;
  logic [WORD_BITS-1:0] hx0, hx1, vy0, vy1;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign pix_accept = accept && (op == OP_PIXEL);

  // effective sizes: zero reads as one, large values clamp to the buffer size
  always_comb begin
    if (frame_width == '0) begin
      ew = SIZE_BITS'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      ew = SIZE_BITS'(MAX_WIDTH);
    end else begin
      ew = frame_width;
    end
    if (frame_height == '0) begin
      eh = SIZE_BITS'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      eh = SIZE_BITS'(MAX_HEIGHT);
    end else begin
      eh = frame_height;
    end
  end

  assign ow    = swap_axes ? eh : ew;
  assign oh    = swap_axes ? ew : eh;
  assign total = POS_BITS'(ew) * POS_BITS'(eh);

  // counters left out of range by a geometry change restart at zero
  assign wp_cur = (write_position >= total) ? '0 : write_position;
  assign rc_cur = (read_column >= ow) ? '0 : read_column;
  assign rr_cur = (read_row >= oh) ? '0 : read_row;

  assign mrow = swap_axes ? rc_cur : rr_cur;
  assign mcol = swap_axes ? rr_cur : rc_cur;
  assign sx   = mirror_horizontal ? (ew - 1'b1 - mcol) : mcol;
  assign sy   = mirror_vertical ? (eh - 1'b1 - mrow) : mrow;
  assign src  = POS_BITS'(sy) * POS_BITS'(ew) + POS_BITS'(sx);

  assign wp_inc     = wp_cur + 1'b1;
  assign frame_wrap = (wp_inc >= total);
  assign rc_inc     = {1'b0, rc_cur} + 1'b1;
  assign rr_inc     = {1'b0, rr_cur} + 1'b1;
  assign col_wrap   = (rc_inc >= {1'b0, ow});
  assign last_c     = (rr_cur == oh - 1'b1) && (rc_cur == ow - 1'b1);

  assign wr_addr = {active_bank, AW'(wp_cur)};
  assign rd_addr = {~active_bank, AW'(src)};

  // region box: mirror reflects about the frame edge, modulo 2^16
  assign hx0 = mirror_horizontal ? (WORD_BITS'(ew) - region_x_end)   : region_x_start;
  assign hx1 = mirror_horizontal ? (WORD_BITS'(ew) - region_x_start) : region_x_end;
  assign vy0 = mirror_vertical   ? (WORD_BITS'(eh) - region_y_end)   : region_y_start;
  assign vy1 = mirror_vertical   ? (WORD_BITS'(eh) - region_y_start) : region_y_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= SIZE_RESET;
      frame_height      <= SIZE_RESET;
      mirror_horizontal <= 1'b0;
      mirror_vertical   <= 1'b0;
      swap_axes         <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_WIDTH:  frame_width       <= wr_data;
        REG_FRAME_HEIGHT: frame_height      <= wr_data;
        REG_MIRROR_H:     mirror_horizontal <= wr_data[0];
        REG_MIRROR_V:     mirror_vertical   <= wr_data[0];
        REG_SWAP_AXES:    swap_axes         <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      read_row       <= '0;
      read_column    <= '0;
      active_bank    <= 1'b0;
      previous_ready <= 1'b0;
    end else if (pix_accept) begin
      if (frame_wrap) begin
        write_position <= '0;
        read_row       <= '0;
        read_column    <= '0;
        active_bank    <= ~active_bank;
        previous_ready <= 1'b1;
      end else begin
        write_position <= wp_inc;
        if (col_wrap) begin
          read_column <= '0;
          read_row    <= (rr_inc >= {1'b0, oh}) ? '0 : rr_inc[SIZE_BITS-1:0];
        end else begin
          read_column <= rc_inc[SIZE_BITS-1:0];
          read_row    <= rr_cur;
        end
      end
    end
  end

  // frame buffer: write to the active bank, read the other one
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      mem[wr_addr] <= pixel_in[PIXEL_BITS-1:0];
      rd_data      <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_kind <= (op == OP_REGION) ? KIND_REGION : KIND_PIXEL;
      res_valid   <= pix_accept && previous_ready;
      res_last    <= pix_accept && previous_ready && last_c;
      out_width   <= ow;
      out_height  <= oh;
      if (op == OP_REGION) begin
        out_x_start <= swap_axes ? vy0 : hx0;
        out_x_end   <= swap_axes ? vy1 : hx1;
        out_y_start <= swap_axes ? hx0 : vy0;
        out_y_end   <= swap_axes ? hx1 : vy1;
      end else begin
        out_x_start <= '0;
        out_x_end   <= '0;
        out_y_start <= '0;
        out_y_end   <= '0;
      end
    end
  end

  assign pixel_valid = res_valid;
  assign frame_last  = res_last;
  assign pixel_out   = res_valid ? WORD_BITS'(rd_data) : '0;

endmodule

[hw/rtl/ift_checker.sv]
// Port-level checker for the image flip/transpose unit, with its bind.
`include "image_flip_transpose_unit_defines.svh"

module ift_checker
  import ift_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic                 result_kind,
  input logic [WORD_BITS-1:0] pixel_out,
  input logic                 pixel_valid,
  input logic                 frame_last,
  input logic [WORD_BITS-1:0] out_x_start,
  input logic [WORD_BITS-1:0] out_x_end,
  input logic [WORD_BITS-1:0] out_y_start,
  input logic [WORD_BITS-1:0] out_y_end
);

  // every item gives a result on the next cycle, and nothing else does
  `IFT_ASSERT_NEXT(a_item_result, clk, rst, start && !busy, done, "item without result")
  `IFT_ASSERT_NEXT(a_no_stray, clk, rst, !(start && !busy), !done, "result without item")

  `IFT_ASSERT_NOW(a_region_clean, clk, rst, done && (result_kind == KIND_REGION),
                  !pixel_valid && !frame_last && (pixel_out == '0),
                  "region result carries pixel data")

  `IFT_ASSERT_NOW(a_pixel_clean, clk, rst, done && (result_kind == KIND_PIXEL),
                  (out_x_start == '0) && (out_x_end == '0) &&
                  (out_y_start == '0) && (out_y_end == '0),
                  "pixel result carries region data")

  `IFT_ASSERT_NOW(a_last_valid, clk, rst, done && frame_last, pixel_valid,
                  "frame end flagged on invalid pixel")

endmodule

bind image_flip_transpose_unit ift_checker u_ift_checker (.*);
